FILE: rtl/core/mvr_pkg.sv
// Shared types, constants and rounding helper for the row dot-product block.
// No dependencies; used by all modules in rtl/core.
`timescale 1ns / 1ps
`default_nettype none
package mvr_pkg;

  localparam logic [63:0] QNAN_BITS = 64'h7FF8_0000_0000_0000;
  localparam logic [63:0] INF_MAG   = 64'h7FF0_0000_0000_0000;

  typedef struct packed {
    logic [63:0] prod;
    logic        last;
  } prod_item_t;

  typedef enum logic [1:0] {
    ADD_IDLE,
    ADD_SUM,
    ADD_LZC,
    ADD_PACK
  } add_state_t;

  // Round to nearest even and pack; an exponent carry from rounding flows into
  // the exponent field, and a too-large magnitude becomes infinity.
  function automatic logic [63:0] round_pack(input logic sign, input logic [11:0] ebase,
                                             input logic [52:0] mant, input logic g,
                                             input logic st);
    logic        rnd;
    logic [53:0] m2;
    logic [63:0] mag;
    rnd = g & (st | mant[0]);
    m2  = {1'b0, mant} + {53'b0, rnd};
    mag = {ebase, 52'b0} + {10'b0, m2};
    if (mag >= INF_MAG) begin
      return {sign, INF_MAG[62:0]};
    end
    return {sign, mag[62:0]};
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/mvr_mul.sv
// Front end: accepts transactions, classifies special operands and multiplies
// in a five-stage pipeline. Depends on mvr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mvr_mul (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [63:0]        in_matrix_element,
  input  wire logic [63:0]        in_coef_element,
  input  wire logic               in_row_end,
  output logic                    push,
  output mvr_pkg::prod_item_t     push_item,
  input  wire logic               fifo_full
);

  function automatic logic [6:0] lzc106(input logic [105:0] x);
    logic [6:0] n;
    logic       f;
    n = 7'd106;
    f = 1'b0;
    for (int i = 105; i >= 0; i--) begin
      if (!f && x[i]) begin
        n = 7'(105 - i);
        f = 1'b1;
      end
    end
    return n;
  endfunction

  logic en;
  logic v1_r, v2_r, v3_r, v4_r, v5_r;

  logic [53:0] ll_r;
  logic [52:0] lh_r, hl_r;
  logic [51:0] hh_r;
  logic [11:0] ex1_r, ex2_r, ex3_r;
  logic        sg1_r, sg2_r, sg3_r, sg4_r, sg5_r;
  logic        sp1_r, sp2_r, sp3_r, sp4_r, sp5_r;
  logic [63:0] spv1_r, spv2_r, spv3_r, spv4_r, spv5_r;
  logic        ls1_r, ls2_r, ls3_r, ls4_r, ls5_r;
  logic [105:0] p2_r, p3_r, n4_r;
  logic [6:0]  lz3_r;
  logic signed [12:0] e4_r;
  logic [52:0] mant5_r;
  logic        g5_r, st5_r;
  logic [11:0] eb5_r;

  logic [10:0] ea, ec;
  logic [52:0] ma, mc;
  logic [10:0] ea1, ec1;
  logic        a_zero, c_zero, a_nf, c_nf, a_nan, c_nan, sgn;
  logic        spec;
  logic [63:0] specv;
  logic [53:0] mid;
  logic signed [12:0] sh13;
  logic [6:0]  sh7;
  logic [105:0] n5;
  logic        stk;
  logic signed [12:0] eb13;

  assign en       = !v5_r || !fifo_full;
  assign in_stall = !en;
  assign push     = v5_r && !fifo_full;

  always_comb begin
    ea     = in_matrix_element[62:52];
    ec     = in_coef_element[62:52];
    ma     = {(ea != 11'd0), in_matrix_element[51:0]};
    mc     = {(ec != 11'd0), in_coef_element[51:0]};
    ea1    = (ea == 11'd0) ? 11'd1 : ea;
    ec1    = (ec == 11'd0) ? 11'd1 : ec;
    a_zero = (in_matrix_element[62:0] == 63'd0);
    c_zero = (in_coef_element[62:0] == 63'd0);
    a_nf   = (ea == 11'h7FF);
    c_nf   = (ec == 11'h7FF);
    a_nan  = a_nf && (in_matrix_element[51:0] != 52'd0);
    c_nan  = c_nf && (in_coef_element[51:0] != 52'd0);
    sgn    = in_matrix_element[63] ^ in_coef_element[63];
    spec   = 1'b1;
    specv  = 64'd0;
    if ((a_zero && c_nf) || (c_zero && a_nf)) begin
      specv = 64'd0;
    end else if (a_nan || c_nan) begin
      specv = mvr_pkg::QNAN_BITS;
    end else if (a_nf || c_nf) begin
      specv = {sgn, mvr_pkg::INF_MAG[62:0]};
    end else if (a_zero || c_zero) begin
      specv = {sgn, 63'd0};
    end else begin
      spec = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_comb begin
    mid  = {1'b0, lh_r} + {1'b0, hl_r};
    sh13 = 13'sd1 - e4_r;
    sh7  = sh13[6:0];
    n5   = n4_r;
    stk  = 1'b0;
    eb13 = e4_r - 13'sd1;
    if (e4_r < 13'sd1) begin
      eb13 = 13'sd0;
      if (sh13 >= 13'sd106) begin
        n5  = 106'd0;
        stk = |n4_r;
      end else begin
        n5  = n4_r >> sh7;
        stk = |(n4_r << (7'd106 - sh7));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ll_r   <= ma[26:0] * mc[26:0];
      lh_r   <= ma[26:0] * mc[52:27];
      hl_r   <= ma[52:27] * mc[26:0];
      hh_r   <= ma[52:27] * mc[52:27];
      ex1_r  <= {1'b0, ea1} + {1'b0, ec1};
      sg1_r  <= sgn;
      sp1_r  <= spec;
      spv1_r <= specv;
      ls1_r  <= in_row_end;

      p2_r   <= {hh_r, 54'b0} + {25'b0, mid, 27'b0} + {52'b0, ll_r};
      ex2_r  <= ex1_r;
      sg2_r  <= sg1_r;
      sp2_r  <= sp1_r;
      spv2_r <= spv1_r;
      ls2_r  <= ls1_r;

      lz3_r  <= lzc106(p2_r);
      p3_r   <= p2_r;
      ex3_r  <= ex2_r;
      sg3_r  <= sg2_r;
      sp3_r  <= sp2_r;
      spv3_r <= spv2_r;
      ls3_r  <= ls2_r;

      n4_r   <= p3_r << lz3_r;
      e4_r   <= $signed({1'b0, ex3_r}) - $signed({6'b0, lz3_r}) - 13'sd1022;
      sg4_r  <= sg3_r;
      sp4_r  <= sp3_r;
      spv4_r <= spv3_r;
      ls4_r  <= ls3_r;

      mant5_r <= n5[105:53];
      g5_r    <= n5[52];
      st5_r   <= (|n5[51:0]) | stk;
      eb5_r   <= (eb13 > 13'sd2047) ? 12'd2047 : eb13[11:0];
      sg5_r   <= sg4_r;
      sp5_r   <= sp4_r;
      spv5_r  <= spv4_r;
      ls5_r   <= ls4_r;
    end
  end

  always_comb begin
    push_item.last = ls5_r;
    push_item.prod = sp5_r ? spv5_r :
                     mvr_pkg::round_pack(sg5_r, eb5_r, mant5_r, g5_r, st5_r);
  end

endmodule
`default_nettype wire

FILE: rtl/core/mvr_fifo.sv
// Short queue of products between the multiplier and the accumulator.
// Depends on mvr_pkg for the entry type.
`timescale 1ns / 1ps
`default_nettype none
module mvr_fifo #(
  parameter int DEPTH = 4
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire mvr_pkg::prod_item_t din,
  output logic                     full,
  input  wire logic                pop,
  output mvr_pkg::prod_item_t      dout,
  output logic                     empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  mvr_pkg::prod_item_t mem [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;

  assign full  = (cnt_r == (AW+1)'(DEPTH));
  assign empty = (cnt_r == '0);
  assign dout  = mem[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp_r] <= din;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/mvr_add.sv
// Back end: four-step sequencer that adds each product into the running sum
// and emits the row sum. Depends on mvr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mvr_add (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                fifo_empty,
  input  wire mvr_pkg::prod_item_t head,
  output logic                     pop,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [63:0]              out_row_sum
);

  function automatic logic [5:0] lzc56(input logic [55:0] x);
    logic [5:0] n;
    logic       f;
    n = 6'd56;
    f = 1'b0;
    for (int i = 55; i >= 0; i--) begin
      if (!f && x[i]) begin
        n = 6'(55 - i);
        f = 1'b1;
      end
    end
    return n;
  endfunction

  mvr_pkg::add_state_t state_r, state_nxt;

  logic [63:0] acc_r;
  logic        out_valid_r;
  logic [63:0] out_row_sum_r;
  logic [52:0] mb_r, ms_r;
  logic [10:0] eb_r, d_r;
  logic        sub_r, sgn_r, spec_r, last_r;
  logic [63:0] specv_r;
  logic [56:0] s_r;
  logic        cy_r;
  logic [5:0]  sh_r;

  logic        fire, blocked;
  logic [63:0] x, y;
  logic        x_nan, y_nan, x_inf, y_inf, x_zero, y_zero, swap;
  logic        spec;
  logic [63:0] specv;
  logic [10:0] ex, ey, ex1, ey1;
  logic [55:0] bsh, al;
  logic        ast;
  logic [56:0] s;
  logic [5:0]  lz;
  logic [10:0] lim;
  logic [55:0] n;
  logic [11:0] e12;
  logic [63:0] res;

  assign out_valid   = out_valid_r;
  assign out_row_sum = out_row_sum_r;

  always_comb begin
    state_nxt = state_r;
    pop       = 1'b0;
    blocked   = out_valid_r && out_stall;
    fire      = 1'b0;
    case (state_r)
      mvr_pkg::ADD_IDLE: begin
        if (!fifo_empty) begin
          pop       = 1'b1;
          state_nxt = mvr_pkg::ADD_SUM;
        end
      end
      mvr_pkg::ADD_SUM: state_nxt = mvr_pkg::ADD_LZC;
      mvr_pkg::ADD_LZC: state_nxt = mvr_pkg::ADD_PACK;
      mvr_pkg::ADD_PACK: begin
        if (!(last_r && blocked)) begin
          fire      = 1'b1;
          state_nxt = mvr_pkg::ADD_IDLE;
        end
      end
      default: state_nxt = mvr_pkg::ADD_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mvr_pkg::ADD_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    x      = acc_r;
    y      = head.prod;
    ex     = x[62:52];
    ey     = y[62:52];
    ex1    = (ex == 11'd0) ? 11'd1 : ex;
    ey1    = (ey == 11'd0) ? 11'd1 : ey;
    x_inf  = (ex == 11'h7FF) && (x[51:0] == 52'd0);
    y_inf  = (ey == 11'h7FF) && (y[51:0] == 52'd0);
    x_nan  = (ex == 11'h7FF) && (x[51:0] != 52'd0);
    y_nan  = (ey == 11'h7FF) && (y[51:0] != 52'd0);
    x_zero = (x[62:0] == 63'd0);
    y_zero = (y[62:0] == 63'd0);
    swap   = (y[62:0] > x[62:0]);
    spec   = 1'b1;
    specv  = 64'd0;
    if (x_nan || y_nan || (x_inf && y_inf && (x[63] != y[63]))) begin
      specv = mvr_pkg::QNAN_BITS;
    end else if (x_inf) begin
      specv = x;
    end else if (y_inf) begin
      specv = y;
    end else if (x_zero && y_zero) begin
      specv = {x[63] & y[63], 63'd0};
    end else if (x_zero) begin
      specv = y;
    end else if (y_zero) begin
      specv = x;
    end else begin
      spec = 1'b0;
    end
  end

  always_comb begin
    bsh = {ms_r, 3'b0};
    if (d_r >= 11'd56) begin
      al  = 56'd0;
      ast = |ms_r;
    end else begin
      al  = bsh >> d_r[5:0];
      ast = |(bsh << (6'd56 - d_r[5:0]));
    end
    if (sub_r) begin
      s = {1'b0, mb_r, 3'b0} - {1'b0, al[55:1], al[0] | ast};
    end else begin
      s = {1'b0, mb_r, 3'b0} + {1'b0, al[55:1], al[0] | ast};
    end
    lz  = lzc56(s_r[55:0]);
    lim = eb_r - 11'd1;
    if (cy_r) begin
      n   = {s_r[56:2], s_r[1] | s_r[0]};
      e12 = {1'b0, eb_r} + 12'd1;
    end else begin
      n   = s_r[55:0] << sh_r;
      e12 = {1'b0, eb_r} - {6'b0, sh_r};
    end
    if (spec_r) begin
      res = specv_r;
    end else if (s_r == 57'd0) begin
      res = 64'd0;
    end else begin
      res = mvr_pkg::round_pack(sgn_r, e12 - 12'd1, n[55:3], n[2], |n[1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= 64'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        acc_r <= last_r ? 64'd0 : res;
      end
      if (fire && last_r) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && last_r) begin
      out_row_sum_r <= (res[62:0] > mvr_pkg::INF_MAG[62:0]) ? mvr_pkg::QNAN_BITS : res;
    end
    if (pop) begin
      last_r  <= head.last;
      spec_r  <= spec;
      specv_r <= specv;
      sub_r   <= x[63] ^ y[63];
      sgn_r   <= swap ? y[63] : x[63];
      mb_r    <= swap ? {(ey != 11'd0), y[51:0]} : {(ex != 11'd0), x[51:0]};
      ms_r    <= swap ? {(ex != 11'd0), x[51:0]} : {(ey != 11'd0), y[51:0]};
      eb_r    <= swap ? ey1 : ex1;
      d_r     <= swap ? (ey1 - ex1) : (ex1 - ey1);
    end
    if (state_r == mvr_pkg::ADD_SUM) begin
      s_r <= s;
    end
    if (state_r == mvr_pkg::ADD_LZC) begin
      cy_r <= s_r[56];
      sh_r <= ({5'b0, lz} > lim) ? lim[5:0] : lz;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/matvec_row_dot_zero_masks_inf.sv
// Top level of the double-precision row dot product: multiplier front end,
// product queue and accumulating back end. Depends on mvr_pkg, mvr_mul,
// mvr_fifo and mvr_add.
//
// Each transaction carries one matrix entry, its coefficient and an end-of-row
// flag. The front end accepts one transaction per cycle into a five-stage
// multiply pipeline while in_stall is low; products wait in a queue of
// FIFO_DEPTH entries. The accumulator adds one product at a time and takes
// no new one until the previous sum is done, since each addition depends on
// that sum, which sets the sustained rate. A row sum is registered once its
// last product is added; NaN sums are emitted as the canonical quiet NaN.
`timescale 1ns / 1ps
`default_nettype none
module matvec_row_dot_zero_masks_inf #(
  parameter int FIFO_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [63:0] in_matrix_element,
  input  wire logic [63:0] in_coef_element,
  input  wire logic        in_row_end,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      out_row_sum
);

  logic                push, pop, full, empty;
  mvr_pkg::prod_item_t push_item, head;

  mvr_mul u_mul (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_matrix_element (in_matrix_element),
    .in_coef_element   (in_coef_element),
    .in_row_end        (in_row_end),
    .push              (push),
    .push_item         (push_item),
    .fifo_full         (full)
  );

  mvr_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (push_item),
    .full  (full),
    .pop   (pop),
    .dout  (head),
    .empty (empty)
  );

  mvr_add u_add (
    .clk         (clk),
    .rst_n       (rst_n),
    .fifo_empty  (empty),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_row_sum (out_row_sum)
  );

endmodule
`default_nettype wire

FILE: sim/matvec_row_dot_zero_masks_inf_test.sv
// Self-checking testbench for the double-precision row dot product block.
// It depends only on the RTL of matvec_row_dot_zero_masks_inf and mvr_pkg.
// Its predictor uses real arithmetic, and it checks every finished row sum.
`timescale 1ns / 1ps
module matvec_row_dot_zero_masks_inf_test;

  localparam int N_RANDOM    = 1830;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [63:0] ABS_MASK = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef struct {
    logic [63:0] matrix;
    logic [63:0] coef;
    logic        row_end;
  } entry_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [63:0] in_matrix_element = '0;
  logic [63:0] in_coef_element = '0;
  logic        in_row_end = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] out_row_sum;

  entry_t      pending_entries[$];
  logic [63:0] row_sums_expected[$];
  logic [63:0] partial_sum = '0;
  int          gap_left = 0;
  int          wait_left = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  int          accepted_count = 0;
  int          error_count = 0;
  int          cycle_count = 0;
  bit          stimulus_done = 1'b0;

  matvec_row_dot_zero_masks_inf dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_matrix_element(in_matrix_element), .in_coef_element(in_coef_element),
    .in_row_end(in_row_end),
    .out_valid(out_valid), .out_stall(out_stall), .out_row_sum(out_row_sum)
  );

  always #6 clk = ~clk;

  function automatic bit is_zero(logic [63:0] b);
    return (b & ABS_MASK) == 64'h0;
  endfunction

  function automatic bit is_nonfinite(logic [63:0] b);
    return (b & mvr_pkg::INF_MAG) == mvr_pkg::INF_MAG;
  endfunction

  function automatic logic [63:0] masked_product(logic [63:0] a, logic [63:0] c);
    if ((is_zero(a) && is_nonfinite(c)) || (is_zero(c) && is_nonfinite(a))) begin
      return 64'h0;
    end
    return $realtobits($bitstoreal(a) * $bitstoreal(c));
  endfunction

  task automatic accumulate_entry(logic [63:0] a, logic [63:0] c, logic last);
    logic [63:0] sum;
    sum = $realtobits($bitstoreal(partial_sum) + $bitstoreal(masked_product(a, c)));
    if (last) begin
      row_sums_expected.push_back(((sum & ABS_MASK) > mvr_pkg::INF_MAG) ?
                                  mvr_pkg::QNAN_BITS : sum);
      partial_sum = 64'h0;
    end else begin
      partial_sum = sum;
    end
  endtask

  function automatic logic [63:0] random_double();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: v = {v[63], 63'h0};
      1: v = {v[63], mvr_pkg::INF_MAG[62:0]};
      2: v = {v[63], 11'h7FF, v[51:0] | 52'h1};
      3: v = {v[63], 11'h000, v[51:0]};
      4: v = {v[63], 11'h7FE, v[51:0]};
      5, 6: v = {v[63], 11'(1023 - 30 + $urandom_range(0, 60)), v[51:0]};
      7: v = {v[63], 11'(1023 - 2 + $urandom_range(0, 4)), 52'h0};
      default: ;
    endcase
    return v;
  endfunction

  task automatic add_entry(logic [63:0] a, logic [63:0] c, logic last);
    entry_t e;
    e.matrix = a;
    e.coef = c;
    e.row_end = last;
    pending_entries.push_back(e);
  endtask

  initial begin
    int remaining;
    int row_len;
    // Zero against infinity or NaN in either position and with either sign.
    add_entry(64'h0, mvr_pkg::INF_MAG, 1'b1);
    add_entry(64'hFFF0_0000_0000_0000, 64'h8000_0000_0000_0000, 1'b1);
    add_entry(64'h8000_0000_0000_0000, 64'h7FF0_0000_0000_0001, 1'b0);
    add_entry(64'hFFF8_1234_0000_0000, 64'h0, 1'b1);
    // A NaN product, and infinities of both signs cancelling to NaN.
    add_entry(64'hFFF8_1234_0000_0000, 64'h3FF0_0000_0000_0000, 1'b1);
    add_entry(mvr_pkg::INF_MAG, 64'h3FF0_0000_0000_0000, 1'b0);
    add_entry(64'hFFF0_0000_0000_0000, 64'h3FF0_0000_0000_0000, 1'b1);
    // Rows of negative zero products, and overflow from the largest values.
    add_entry(64'h8000_0000_0000_0000, 64'h3FF0_0000_0000_0000, 1'b0);
    add_entry(64'h0, 64'hBFF0_0000_0000_0000, 1'b1);
    add_entry(64'h7FEF_FFFF_FFFF_FFFF, 64'h7FEF_FFFF_FFFF_FFFF, 1'b1);
    add_entry(64'h7FEF_FFFF_FFFF_FFFF, 64'h3FF0_0000_0000_0000, 1'b0);
    add_entry(64'h7FEF_FFFF_FFFF_FFFF, 64'h3FF0_0000_0000_0000, 1'b1);
    // Subnormal products and cancellation to zero.
    add_entry(64'h0000_0000_0000_0001, 64'h3FE0_0000_0000_0000, 1'b0);
    add_entry(64'h000F_FFFF_FFFF_FFFF, 64'h3FF8_0000_0000_0000, 1'b1);
    add_entry(64'h3FF0_0000_0000_0001, 64'h4000_0000_0000_0000, 1'b0);
    add_entry(64'hBFF0_0000_0000_0001, 64'h4000_0000_0000_0000, 1'b1);
    add_entry(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    remaining = N_RANDOM;
    while (remaining > 0) begin
      row_len = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6);
      for (int i = 0; i < row_len && remaining > 0; i++) begin
        remaining--;
        add_entry(random_double(), random_double(), (i == row_len - 1) || remaining == 0);
      end
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
  end

  always @(posedge clk) begin
    entry_t e;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        accumulate_entry(in_matrix_element, in_coef_element, in_row_end);
        accepted_count++;
      end
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_entries.size() > 0) begin
          e = pending_entries.pop_front();
          in_matrix_element <= e.matrix;
          in_coef_element <= e.coef;
          in_row_end <= e.row_end;
          in_valid <= 1'b1;
          gap_left <= ((accepted_count / 200) % 3 == 1) ? 0 : $urandom_range(0, 8);
        end else begin
          in_valid <= 1'b0;
          stimulus_done <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    logic [63:0] want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (row_sums_expected.size() == 0) begin
          $display("%0t: unexpected row sum %h", $time, out_row_sum);
          error_count++;
        end else begin
          want = row_sums_expected.pop_front();
          if (out_row_sum !== want) begin
            $display("%0t: row_sum expected %h actual %h", $time, want, out_row_sum);
            error_count++;
          end
        end
        wait_left = ((accepted_count / 200) % 3 == 2) ? 0 : $urandom_range(0, 8);
      end
      if (!hold_done && accepted_count >= 600) begin
        hold_done = 1'b1;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (wait_left > 0) begin
        wait_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    wait (stimulus_done && !in_valid && row_sums_expected.size() == 0);
    repeat (40) @(posedge clk);
    if (error_count == 0 && row_sums_expected.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
